FILE: rtl/utf16_to_utf8_byte_queue_assert.svh
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 byte queue assertion macros
// Concurrent checks on the clock and active-low reset of the block.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_BYTE_QUEUE_ASSERT_SVH
`define UTF16_TO_UTF8_BYTE_QUEUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define U2U8Q_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u2u8q assertion failed");
`define U2U8Q_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u2u8q assertion failed");
`else
`define U2U8Q_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define U2U8Q_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/u2u8q_pkg.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 byte queue package
// Request and status codes, payload structs and encoder result type.
// ----------------------------------------------------------------------------
package u2u8q_pkg;

  localparam logic [1:0] REQ_PUSH_BYTE = 2'd0;
  localparam logic [1:0] REQ_PUSH_UNIT = 2'd1;
  localparam logic [1:0] REQ_READ      = 2'd2;
  localparam logic [1:0] REQ_PEEK      = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_HELD  = 2'd3;

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] status;
    logic [7:0] fill_count;
    logic       surrogate_pending;
  } out_t;

  typedef struct packed {
    logic [5:0][7:0] bytes;
    logic [2:0]      len;
    logic            held_next;
    logic [9:0]      bits_next;
    logic            hold_only;
  } enc_t;

endpackage

FILE: rtl/u2u8q_enc.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder
// Turns one push request and the held surrogate into up to six bytes.
// ----------------------------------------------------------------------------
module u2u8q_enc import u2u8q_pkg::*; (
  input  logic [1:0]  req_i,
  input  logic [15:0] value_i,
  input  logic        held_i,
  input  logic [9:0]  held_bits_i,
  output enc_t        enc_o
);

  logic [3:0][7:0] body;
  logic [2:0]      body_len;
  logic            prefix;
  logic            is_high;
  logic            is_low;
  logic            is_surr;
  logic [20:0]     cp;
  logic            held_next;
  logic [9:0]      bits_next;
  logic            hold_only;
  logic [5:0][7:0] out_bytes;
  logic [2:0]      out_len;

  assign is_high = (value_i[15:10] == 6'b110110);
  assign is_low  = (value_i[15:10] == 6'b110111);
  assign is_surr = (value_i[15:11] == 5'b11011);
  assign cp      = {1'b0, held_bits_i, value_i[9:0]} + 21'h10000;

  always_comb begin
    body      = '0;
    body_len  = 3'd0;
    prefix    = held_i;
    held_next = 1'b0;
    bits_next = held_bits_i;
    hold_only = 1'b0;
    case (req_i)
      REQ_PUSH_BYTE: begin
        body[0]  = value_i[7:0];
        body_len = 3'd1;
      end
      REQ_PUSH_UNIT: begin
        if (is_high) begin
          held_next = 1'b1;
          bits_next = value_i[9:0];
          hold_only = !held_i;
        end else if (held_i && is_low) begin
          prefix   = 1'b0;
          body[0]  = {5'b11110, cp[20:18]};
          body[1]  = {2'b10, cp[17:12]};
          body[2]  = {2'b10, cp[11:6]};
          body[3]  = {2'b10, cp[5:0]};
          body_len = 3'd4;
        end else if (value_i < 16'h0080) begin
          body[0]  = value_i[7:0];
          body_len = 3'd1;
        end else if (value_i < 16'h0800) begin
          body[0]  = {3'b110, value_i[10:6]};
          body[1]  = {2'b10, value_i[5:0]};
          body_len = 3'd2;
        end else if (is_surr) begin
          body[0]  = REPL_B0;
          body[1]  = REPL_B1;
          body[2]  = REPL_B2;
          body_len = 3'd3;
        end else begin
          body[0]  = {4'b1110, value_i[15:12]};
          body[1]  = {2'b10, value_i[11:6]};
          body[2]  = {2'b10, value_i[5:0]};
          body_len = 3'd3;
        end
      end
      default: begin
        prefix    = 1'b0;
        held_next = held_i;
      end
    endcase
  end

  always_comb begin
    out_bytes = '0;
    if (prefix) begin
      out_bytes[0] = REPL_B0;
      out_bytes[1] = REPL_B1;
      out_bytes[2] = REPL_B2;
      out_bytes[3] = body[0];
      out_bytes[4] = body[1];
      out_bytes[5] = body[2];
      out_len      = body_len + 3'd3;
    end else begin
      out_bytes[3:0] = body;
      out_len        = body_len;
    end
  end

  assign enc_o = {out_bytes, out_len, held_next, bits_next, hold_only};

endmodule

FILE: rtl/utf16_to_utf8_byte_queue.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 byte queue
// Transcodes pushes into a circular byte queue and serves read and peek.
// ----------------------------------------------------------------------------
// One request is handled at a time. A push is encoded and then writes its
// UTF-8 bytes (0 to 6) to the queue one after another, since the queue memory
// has one port and takes one byte per cycle; a read or peek waits for the
// registered memory read, which is skipped when the queue is empty. A
// rejected push (queue full) or a held high surrogate queues no bytes. The
// next request is taken in the cycle after the result is loaded into the
// output register.
module utf16_to_utf8_byte_queue import u2u8q_pkg::*; #(
  parameter int QUEUE_DEPTH = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

`include "utf16_to_utf8_byte_queue_assert.svh"

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ENC    = 3'd1;
  localparam logic [2:0] S_WRITE  = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [1:0]       req_q;
  logic [15:0]      value_q;
  logic [IDX_W-1:0] head_q, tail_q;
  logic [CNT_W-1:0] count_q;
  logic             held_q;
  logic [9:0]       held_bits_q;
  logic [5:0][7:0]  bytes_q;
  logic [2:0]       len_q;
  logic [2:0]       wr_idx_q;
  logic [7:0]       data_q;
  logic [1:0]       status_q;
  logic             out_valid_q;
  out_t             out_q;

  logic [7:0]       mem_q [QUEUE_DEPTH];
  logic [7:0]       rdata_q;
  logic             mem_we, mem_re;

  enc_t             enc;
  logic [CNT_W:0]   need;
  logic             no_room;
  logic             is_push;
  logic [CNT_W+7:0] count_ext;

  u2u8q_enc u_enc (
    .req_i       (req_q),
    .value_i     (value_q),
    .held_i      (held_q),
    .held_bits_i (held_bits_q),
    .enc_o       (enc)
  );

  assign need      = (CNT_W+1)'(count_q) + (CNT_W+1)'(enc.len);
  assign no_room   = need > (CNT_W+1)'(QUEUE_DEPTH);
  assign is_push   = (req_q == REQ_PUSH_BYTE) || (req_q == REQ_PUSH_UNIT);
  assign count_ext = {8'd0, count_q};

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign mem_we = (state_q == S_WRITE);
  assign mem_re = (state_q == S_ENC) && !is_push && (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= bytes_q[wr_idx_q];
    end
    if (mem_re) begin
      rdata_q <= mem_q[head_q];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_ENC;
        end
      end
      S_ENC: begin
        if (!is_push) begin
          state_d = (count_q == '0) ? S_DONE : S_RDWAIT;
        end else if (no_room || enc.len == 3'd0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        if (wr_idx_q == len_q - 3'd1) begin
          state_d = S_DONE;
        end
      end
      S_RDWAIT: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      held_q      <= 1'b0;
      held_bits_q <= '0;
      wr_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_ENC: begin
          wr_idx_q <= '0;
          if (is_push && !no_room) begin
            held_q      <= enc.held_next;
            held_bits_q <= enc.bits_next;
          end
        end
        S_WRITE: begin
          wr_idx_q <= wr_idx_q + 3'd1;
          count_q  <= count_q + CNT_W'(1);
          tail_q   <= (tail_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + IDX_W'(1);
        end
        S_RDWAIT: begin
          if (req_q == REQ_READ) begin
            count_q <= count_q - CNT_W'(1);
            head_q  <= (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
          end
        end
        default: begin
        end
      endcase
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q   <= in_data_i.req_type;
      value_q <= in_data_i.value;
    end
    if (state_q == S_ENC) begin
      bytes_q <= enc.bytes;
      len_q   <= enc.len;
      data_q  <= '0;
      if (!is_push) begin
        status_q <= (count_q == '0) ? ST_EMPTY : ST_OK;
      end else if (no_room) begin
        status_q <= ST_FULL;
      end else if (enc.hold_only) begin
        status_q <= ST_HELD;
      end else begin
        status_q <= ST_OK;
      end
    end
    if (state_q == S_RDWAIT) begin
      data_q <= rdata_q;
    end
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_q.data_byte         <= data_q;
      out_q.status            <= status_q;
      out_q.fill_count        <= count_ext[7:0];
      out_q.surrogate_pending <= held_q;
    end
  end

  `U2U8Q_ASSERT_IMPLY(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH))
  `U2U8Q_ASSERT_IMPLY(a_write_room, clk_i, rst_ni, state_q == S_WRITE, count_q < CNT_W'(QUEUE_DEPTH))
  `U2U8Q_ASSERT_IMPLY(a_read_nonempty, clk_i, rst_ni, state_q == S_RDWAIT, count_q != '0)
  `U2U8Q_ASSERT_IMPLY(a_empty_zero, clk_i, rst_ni, out_valid_q && out_q.status == ST_EMPTY, out_q.data_byte == 8'd0)

endmodule
